// ===== hw/rtl/vsgm_pkg.sv =====
package vsgm_pkg;

  localparam int FRAME_BITS  = 24;
  localparam int GAP_BITS    = 16;
  localparam int PITCH_BITS  = 32;
  localparam int MAX_SEGS    = 3;
  localparam int SEL_BITS    = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [GAP_BITS-1:0]   gap_t;
  typedef logic [SEL_BITS-1:0]   sel_t;

  localparam frame_t FRAME_MAX = '1;

  typedef struct packed {
    frame_t start;
    frame_t stop;
    logic   voiced;
  } seg_t;

  // One queue entry: the segments caused by one frame.
  typedef struct packed {
    sel_t                   count;
    logic                   done;
    seg_t [MAX_SEGS-1:0]    seg;
  } entry_t;

  function automatic frame_t sat_inc(frame_t x);
    return (x == FRAME_MAX) ? x : x + frame_t'(1);
  endfunction

endpackage

// ===== hw/rtl/vsgm_front.sv =====
module vsgm_front import vsgm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  gap_t                         cfg_wdata,
  input  logic signed [PITCH_BITS-1:0] pitch,
  input  logic                         last_frame,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         q_ready,
  output logic                         push,
  output entry_t                       push_entry
);

  gap_t   min_gap_frames;
  frame_t frame_index;
  frame_t run_start;
  logic   run_is_voiced;
  logic   pending_valid;
  frame_t pending_start;
  logic   in_sequence;

  logic   accept;
  logic   voiced;
  frame_t end_idx;
  frame_t rs, ps;
  logic   rv, pv;
  sel_t   n;
  entry_t ent;

  assign in_ready = q_ready;
  assign accept   = in_valid & q_ready;
  assign voiced   = !pitch[PITCH_BITS-1] && (pitch != '0);
  assign end_idx  = sat_inc(frame_index);

  always_comb begin
    rs  = run_start;
    rv  = run_is_voiced;
    pv  = pending_valid;
    ps  = pending_start;
    n   = '0;
    ent = '0;
    if (!in_sequence) begin
      rs = frame_index;
      rv = voiced;
      pv = 1'b0;
      ps = '0;
    end else if (voiced != run_is_voiced) begin
      // A voiced run ending, or a short gap ending, opens or extends the voiced segment.
      if (run_is_voiced ||
          ((frame_index - run_start) < {{(FRAME_BITS-GAP_BITS){1'b0}}, min_gap_frames})) begin
        if (!pv) begin
          ps = run_start;
          pv = 1'b1;
        end
      end else begin
        if (pv) begin
          ent.seg[n] = '{start: ps, stop: run_start, voiced: 1'b1};
          n = n + sel_t'(1);
        end
        ent.seg[n] = '{start: run_start, stop: frame_index, voiced: 1'b0};
        n = n + sel_t'(1);
        pv = 1'b0;
      end
      rs = frame_index;
      rv = voiced;
    end

    if (last_frame) begin
      if (rv) begin
        if (!pv) begin
          ps = rs;
        end
        ent.seg[n] = '{start: ps, stop: end_idx, voiced: 1'b1};
        n = n + sel_t'(1);
      end else if (((end_idx - rs) < {{(FRAME_BITS-GAP_BITS){1'b0}}, min_gap_frames}) &&
                   (rs != '0) && pv) begin
        // A short trailing gap is absorbed into the open voiced segment.
        ent.seg[n] = '{start: ps, stop: end_idx, voiced: 1'b1};
        n = n + sel_t'(1);
      end else begin
        if (pv) begin
          ent.seg[n] = '{start: ps, stop: rs, voiced: 1'b1};
          n = n + sel_t'(1);
        end
        ent.seg[n] = '{start: rs, stop: end_idx, voiced: 1'b0};
        n = n + sel_t'(1);
      end
      ent.done = 1'b1;
    end
    ent.count = n;
  end

  assign push       = accept && (n != '0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_frames <= '0;
      frame_index    <= '0;
      run_start      <= '0;
      run_is_voiced  <= 1'b0;
      pending_valid  <= 1'b0;
      pending_start  <= '0;
      in_sequence    <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_gap_frames <= cfg_wdata;
      end
      if (accept) begin
        if (last_frame) begin
          frame_index   <= '0;
          run_start     <= '0;
          run_is_voiced <= 1'b0;
          pending_valid <= 1'b0;
          pending_start <= '0;
          in_sequence   <= 1'b0;
        end else begin
          frame_index   <= end_idx;
          run_start     <= rs;
          run_is_voiced <= rv;
          pending_valid <= pv;
          pending_start <= ps;
          in_sequence   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/vsgm_queue.sv =====
module vsgm_queue import vsgm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   q_ready,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign q_ready    = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/vsgm_back.sv =====
module vsgm_back import vsgm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  output frame_t seg_start,
  output frame_t seg_end,
  output logic   seg_voiced,
  output logic   run_last,
  output logic   sequence_done,
  output logic   out_valid,
  input  logic   out_ready
);

  sel_t sel;
  seg_t cur;
  logic last_seg;

  assign cur           = head.seg[sel];
  assign last_seg      = (sel == (head.count - sel_t'(1)));
  assign out_valid     = head_valid;
  assign seg_start     = cur.start;
  assign seg_end       = cur.stop;
  assign seg_voiced    = cur.voiced;
  assign run_last      = last_seg;
  assign sequence_done = last_seg && head.done;
  assign pop           = head_valid && out_ready && last_seg;

  // Walks through the segments of the head entry, one word per cycle while out_ready is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (head_valid && out_ready) begin
      sel <= last_seg ? '0 : sel + sel_t'(1);
    end
  end

endmodule

// ===== hw/rtl/voicing_segmenter_gap_merge.sv =====
// Voicing segmenter: takes up to one pitch frame per cycle and gives voiced and unvoiced
// segments as [seg_start, seg_end) frame indices, with short unvoiced gaps absorbed into
// their voiced neighbours. A frame is taken in every cycle while the four-entry result
// queue has room; each frame yields zero to three segment words, and the output side
// drains them at one word per cycle while out_ready is high, so sustained rate is one
// frame per cycle when frames average at most one segment, and otherwise is set by the
// output port. A frame's segment words pass through the result queue before they are
// offered. min_gap_frames may be written only while the block is idle.
module voicing_segmenter_gap_merge import vsgm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  gap_t                         cfg_wdata,
  input  logic signed [PITCH_BITS-1:0] pitch,
  input  logic                         last_frame,
  input  logic                         in_valid,
  output logic                         in_ready,
  output frame_t                       seg_start,
  output frame_t                       seg_end,
  output logic                         seg_voiced,
  output logic                         run_last,
  output logic                         sequence_done,
  output logic                         out_valid,
  input  logic                         out_ready
);

  logic   q_ready;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  vsgm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pitch      (pitch),
    .last_frame (last_frame),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  vsgm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  vsgm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .seg_start     (seg_start),
    .seg_end       (seg_end),
    .seg_voiced    (seg_voiced),
    .run_last      (run_last),
    .sequence_done (sequence_done),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule

// ===== hw/rtl/vsgm_checker.sv =====
module vsgm_checker import vsgm_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   out_valid,
  input logic   out_ready,
  input frame_t seg_start,
  input frame_t seg_end,
  input logic   run_last,
  input logic   sequence_done
);

  // A word that is offered but not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn before it was taken");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seg_start <= seg_end)
    else $error("segment ends before it starts");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_done |-> run_last)
    else $error("end of sequence not on the last word of its frame");

  // The result queue is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid just after reset");

endmodule

bind voicing_segmenter_gap_merge vsgm_checker u_vsgm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .seg_start     (seg_start),
  .seg_end       (seg_end),
  .run_last      (run_last),
  .sequence_done (sequence_done)
);
